[src/rbfk_pkg.sv]
`default_nettype none

package rbfk_pkg;

   localparam int EXP_TABLE_DEPTH_DEF = 256;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int ACC_W = 40;
   localparam int MUL_W = 40;

   localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
   localparam logic [63:0] LN2_Q32 = 64'd2977044472;

   localparam logic [CSR_INDEX_W-1:0] CSR_VARIANCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_LENGTH_SQ = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_LENGTH_CUBED = 2'd2;

   typedef struct packed {
      logic signed [15:0] coord_a;
      logic signed [15:0] coord_b;
      logic last_coord;
   } req_type;

   typedef struct packed {
      logic [23:0] kernel_value;
      logic [15:0] exp_weight;
      logic [31:0] length_grad;
      logic saturated;
   } rsp_type;

   // one finished squared distance, handed from front to back
   typedef struct packed {
      logic [ACC_W-1:0] dist_sq;
      logic clipped;
   } job_type;

   typedef struct packed {
      logic [23:0] variance;
      logic [23:0] inv_length_sq;
      logic [23:0] inv_length_cubed;
   } cfg_type;

   // 2^(-i/depth) in Q.32 from the exp(-z) series, z = i*ln2/depth in Q.32
   function automatic logic [32:0] pow2_neg_entry(input logic [63:0] z);
      logic [63:0] term;
      logic signed [64:0] sum;
      logic [63:0] prod;
      term = 64'd1 << 32;
      sum = 65'sd4294967296;
      for (int n = 1; n < 30; n++) begin
         if (term != 64'd0) begin
            prod = term * z;
            term = (prod >> 32) / 64'(n);
            if (n % 2 == 1) begin
               sum = sum - $signed({1'b0, term});
            end else begin
               sum = sum + $signed({1'b0, term});
            end
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      return sum[32:0];
   endfunction

endpackage

`default_nettype wire

[src/rbfk_front.sv]
`default_nettype none

module rbfk_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire rbfk_pkg::req_type req_data,
   input  wire logic            q_full,
   output logic                 q_push,
   output rbfk_pkg::job_type    q_data
);
   import rbfk_pkg::*;

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic clip_ff, clip_in;
   logic signed [16:0] diff;
   logic [15:0] mag;
   logic [31:0] sq;
   logic [ACC_W:0] sum;
   logic [ACC_W-1:0] acc_next;
   logic clip_next;
   logic take;

   assign req_ready = !q_full;
   assign take = req_valid && req_ready;

   always_comb begin
      diff = 17'(req_data.coord_a) - 17'(req_data.coord_b);
      mag = diff[16] ? 16'(-diff) : diff[15:0];
      sq = 32'(mag) * 32'(mag);
      sum = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(sq);
      // clip at full scale on carry out
      acc_next = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
      clip_next = clip_ff | sum[ACC_W];
   end

   always_comb begin
      acc_in = acc_ff;
      clip_in = clip_ff;
      q_push = 1'b0;
      q_data.dist_sq = acc_next;
      q_data.clipped = clip_next;
      if (take) begin
         if (req_data.last_coord) begin
            q_push = 1'b1;
            acc_in = '0;
            clip_in = 1'b0;
         end else begin
            acc_in = acc_next;
            clip_in = clip_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         clip_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         clip_ff <= clip_in;
      end
   end

endmodule

`default_nettype wire

[src/rbfk_queue.sv]
`default_nettype none

module rbfk_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire rbfk_pkg::job_type push_data,
   output logic                 full,
   input  wire logic            pop,
   output rbfk_pkg::job_type    pop_data,
   output logic                 empty
);
   import rbfk_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/rbfk_mul.sv]
`default_nettype none

module rbfk_mul (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [rbfk_pkg::MUL_W-1:0] a,
   input  wire logic [rbfk_pkg::MUL_W-1:0] b,
   output logic                            done,
   output logic [2*rbfk_pkg::MUL_W-1:0]    prod
);
   import rbfk_pkg::*;

   localparam int STEPS = MUL_W / 8;
   localparam int CNT_W = $clog2(STEPS);

   logic [MUL_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [2*MUL_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [MUL_W+7:0] part;

   assign part = (MUL_W + 8)'(a_ff) * (MUL_W + 8)'(b_ff[MUL_W-1 -: 8]);
   assign done = done_ff;
   assign prod = acc_ff;

   // one byte of b per cycle, most significant first
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = a;
         b_in = b;
         acc_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[2*MUL_W-9:0], 8'h00} + (2*MUL_W)'(part);
         b_in = {b_ff[MUL_W-9:0], 8'h00};
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

[src/rbfk_back.sv]
`default_nettype none

module rbfk_back #(
   parameter int EXP_TABLE_DEPTH = rbfk_pkg::EXP_TABLE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rbfk_pkg::cfg_type cfg,
   input  wire logic             q_empty,
   input  wire rbfk_pkg::job_type q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rbfk_pkg::rsp_type     rsp_data
);
   import rbfk_pkg::*;

   localparam int IW = $clog2(EXP_TABLE_DEPTH + 1);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_XMUL  = 10'b0000000010,
      ST_YMUL  = 10'b0000000100,
      ST_IDX   = 10'b0000001000,
      ST_IMUL  = 10'b0000010000,
      ST_ROUND = 10'b0000100000,
      ST_KMUL  = 10'b0001000000,
      ST_GMUL  = 10'b0010000000,
      ST_DMUL  = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } bk_state_type;

   bk_state_type state_ff, state_in;
   logic go_ff, go_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in, res_ff, res_in;

   logic [ACC_W-1:0] d_ff, d_in;
   logic clip_ff, clip_in;
   logic [28:0] x_ff, x_in;
   logic [4:0] k_ff, k_in;
   logic [23:0] f_ff, f_in, r_ff, r_in;
   logic [IW-1:0] idx_ff, idx_in, idx_nx;
   logic [32:0] v_ff, v_in;
   logic [15:0] e_ff, e_in;
   logic [39:0] kv_ff, kv_in, g_ff, g_in;

   logic [32:0] tab [EXP_TABLE_DEPTH + 1];
   logic [32:0] tab_lo, tab_hi;
   logic [24+IW-1:0] p;
   logic [5:0] sh;
   logic [33:0] rsum, rshift;
   logic [40:0] kv_sum;
   logic gclip;

   logic [MUL_W-1:0] mul_a, mul_b;
   logic mul_done;
   logic [2*MUL_W-1:0] mul_prod;

   for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_tab
      localparam logic [63:0] Z = (64'(gi) * LN2_Q32) / 64'(EXP_TABLE_DEPTH);
      assign tab[gi] = pow2_neg_entry(Z);
   end

   assign idx_nx = IW'(idx_ff + 1'b1);
   assign tab_lo = tab[idx_ff];
   assign tab_hi = tab[idx_nx];
   assign p = (24 + IW)'(f_ff) * (24 + IW)'(EXP_TABLE_DEPTH);

   rbfk_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (go_ff),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_XMUL: begin
            mul_a = d_ff;
            mul_b = MUL_W'(cfg.inv_length_sq);
         end
         ST_YMUL: begin
            mul_a = MUL_W'(x_ff);
            mul_b = MUL_W'(LOG2E_Q30);
         end
         ST_IMUL: begin
            mul_a = MUL_W'(tab_lo - tab_hi);
            mul_b = MUL_W'(r_ff);
         end
         ST_KMUL: begin
            mul_a = MUL_W'(cfg.variance);
            mul_b = MUL_W'(e_ff);
         end
         ST_GMUL: begin
            mul_a = kv_ff;
            mul_b = MUL_W'(cfg.inv_length_cubed);
         end
         ST_DMUL: begin
            mul_a = g_ff;
            mul_b = d_ff;
         end
         ST_IDLE, ST_IDX, ST_ROUND, ST_OUT: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      sh = 6'(k_ff) + 6'd16;
      rsum = 34'(v_ff) + (34'd1 << (sh - 6'd1));
      rshift = rsum >> sh;
      kv_sum = 41'(kv_ff) + 41'h8000;
      gclip = |mul_prod[79:64];
   end

   always_comb begin
      state_in = state_ff;
      go_in = 1'b0;
      q_pop = 1'b0;
      d_in = d_ff;
      clip_in = clip_ff;
      x_in = x_ff;
      k_in = k_ff;
      f_in = f_ff;
      idx_in = idx_ff;
      r_in = r_ff;
      v_in = v_ff;
      e_in = e_ff;
      kv_in = kv_ff;
      g_in = g_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               d_in = q_data.dist_sq;
               clip_in = q_data.clipped;
               go_in = 1'b1;
               state_in = ST_XMUL;
            end
         end
         ST_XMUL: begin
            if (mul_done) begin
               go_in = 1'b1;
               // scaled distance at or above 32 in Q.24: exp underflows
               if (|mul_prod[63:46]) begin
                  e_in = '0;
                  state_in = ST_KMUL;
               end else begin
                  x_in = mul_prod[45:17];
                  state_in = ST_YMUL;
               end
            end
         end
         ST_YMUL: begin
            if (mul_done) begin
               if (mul_prod[59:54] > 6'd16) begin
                  e_in = '0;
                  go_in = 1'b1;
                  state_in = ST_KMUL;
               end else begin
                  k_in = mul_prod[58:54];
                  f_in = mul_prod[53:30];
                  state_in = ST_IDX;
               end
            end
         end
         ST_IDX: begin
            idx_in = p[24 +: IW];
            r_in = p[23:0];
            go_in = 1'b1;
            state_in = ST_IMUL;
         end
         ST_IMUL: begin
            if (mul_done) begin
               v_in = 33'(tab_lo - mul_prod[56:24]);
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            e_in = (|rshift[33:16]) ? 16'hFFFF : rshift[15:0];
            go_in = 1'b1;
            state_in = ST_KMUL;
         end
         ST_KMUL: begin
            if (mul_done) begin
               kv_in = mul_prod[39:0];
               go_in = 1'b1;
               state_in = ST_GMUL;
            end
         end
         ST_GMUL: begin
            if (mul_done) begin
               g_in = mul_prod[63:24];
               go_in = 1'b1;
               state_in = ST_DMUL;
            end
         end
         ST_DMUL: begin
            if (mul_done) begin
               res_in.kernel_value = kv_sum[39:16];
               res_in.exp_weight = e_ff;
               res_in.length_grad = gclip ? 32'hFFFF_FFFF : mul_prod[63:32];
               res_in.saturated = clip_ff | gclip;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      clip_ff <= clip_in;
      x_ff <= x_in;
      k_ff <= k_in;
      f_ff <= f_in;
      idx_ff <= idx_in;
      r_ff <= r_in;
      v_ff <= v_in;
      e_ff <= e_in;
      kv_ff <= kv_in;
      g_ff <= g_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[src/rbf_kernel_with_gradients_top.sv]
// Gaussian RBF kernel with lengthscale gradient, one coordinate per request.
// Request channel (req_valid/req_ready/req_data): each request carries one
// coordinate of a point pair in signed Q4.12; last_coord marks the final one.
// The front accumulates the squared difference into a saturating Q16.24
// distance at one request per cycle while the queue has room; on
// last_coord it hands the distance to a two-entry queue and starts the
// next pair at once. The back end computes exp(-0.5*d/l^2) by base-2
// splitting with an interpolated fraction table, then variance*exp and
// the lengthscale gradient, all on one shared 40x8 iterative multiplier;
// each product takes a load, five byte steps and a done flag.
// A scaled distance of 32 or more skips the table steps, and an integer
// exponent above 16 skips interpolation. The back end takes the next
// distance from the queue only after it has handed its last result to
// the result register.
// Response channel (rsp_valid/rsp_ready/rsp_data): a stalled receiver holds
// the result register, then the back end, then the queue; when the queue is
// full req_ready drops. Configuration (csr_*) is always ready; write it only
// while idle. Reset clears the accumulator, queue and sequencer and loads
// 1.0 into all three registers. No clearing pass follows reset.
`default_nettype none

module rbf_kernel_with_gradients_top #(
   parameter int EXP_TABLE_DEPTH = rbfk_pkg::EXP_TABLE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire rbfk_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output rbfk_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rbfk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [23:0]                      csr_wdata
);
   import rbfk_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic q_push, q_pop, q_full, q_empty;
   job_type q_in, q_out;

   // registers take writes at any time; unknown indexes drop the write
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_VARIANCE: cfg_in.variance = csr_wdata;
            CSR_INV_LENGTH_SQ: cfg_in.inv_length_sq = csr_wdata;
            CSR_INV_LENGTH_CUBED: cfg_in.inv_length_cubed = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.variance <= 24'd65536;
         cfg_ff.inv_length_sq <= 24'd65536;
         cfg_ff.inv_length_cubed <= 24'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accumulate, push the distance on the last coordinate
   rbfk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   // decouple: lets the front run on while the back end works a pair
   rbfk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   // back: exponent, kernel value and gradient, then the result register
   rbfk_back #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[src/rbfk_checker.sv]
`default_nettype none

module rbfk_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire rbfk_pkg::rsp_type rsp_data
);

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a zero exponential term forces zero kernel value and gradient
   a_zero_exp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.exp_weight == 16'd0 |->
         rsp_data.kernel_value == 24'd0 && rsp_data.length_grad == 32'd0)
      else $error("nonzero output with zero exponential term");

endmodule

bind rbf_kernel_with_gradients_top rbfk_checker u_rbfk_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[verif/rbf_kernel_with_gradients_checker.sv]
`default_nettype none

module rbf_kernel_with_gradients_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire rbfk_pkg::req_type                   req_data,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire rbfk_pkg::rsp_type                   rsp_data,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   input  wire logic [rbfk_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [23:0]                         csr_wdata,
   output int                                       errors,
   output int                                       outstanding
);
   import rbfk_pkg::*;

   localparam int TAB_N = EXP_TABLE_DEPTH_DEF;
   localparam logic [39:0] DIST_MAX = 40'hFF_FFFF_FFFF;

   logic [63:0] pow2_frac_tab [0:TAB_N];
   logic [39:0] dist_sum;
   logic        dist_clipped;
   logic [23:0] reg_variance, reg_inv_sq, reg_inv_cubed;
   rsp_type     kernel_results [$];

   function automatic logic [63:0] pow2_frac(input int i);
      logic [63:0] z, term;
      logic signed [65:0] sum;
      z = (64'(i) * LN2_Q32) / 64'(TAB_N);
      term = 64'd1 << 32;
      sum = 66'sd4294967296;
      for (int n = 1; n < 30; n++) begin
         if (term != 0) begin
            term = ((term * z) >> 32) / 64'(n);
            if (n % 2 == 1) sum = sum - $signed({2'b0, term});
            else sum = sum + $signed({2'b0, term});
         end
      end
      if (sum < 0) sum = '0;
      return sum[63:0];
   endfunction

   function automatic logic [15:0] exp_half_dist(input logic [39:0] d);
      logic [63:0] x, y, k, f, p, idx, r, v, e;
      x = (64'(d) * 64'(reg_inv_sq)) >> 17;
      if (x >= (64'd1 << 29)) return 16'd0;
      y = (x * LOG2E_Q30) >> 30;
      k = y >> 24;
      f = y & 64'hFF_FFFF;
      if (k > 16) return 16'd0;
      p = f * 64'(TAB_N);
      idx = p >> 24;
      r = p & 64'hFF_FFFF;
      v = pow2_frac_tab[idx]
          - (((pow2_frac_tab[idx] - pow2_frac_tab[idx+1]) * r) >> 24);
      e = (v + (64'd1 << (15 + k))) >> (16 + k);
      if (e > 64'hFFFF) e = 64'hFFFF;
      return e[15:0];
   endfunction

   function automatic rsp_type kernel_of(input logic [39:0] d, input logic clip);
      rsp_type     res;
      logic [63:0] kv, g;
      logic [127:0] gd;
      logic [15:0] e;
      e = exp_half_dist(d);
      kv = 64'(reg_variance) * 64'(e);
      g = (kv * 64'(reg_inv_cubed)) >> 24;
      gd = 128'(g) * 128'(d);
      res.kernel_value = 24'((kv + 64'h8000) >> 16);
      res.exp_weight = e;
      res.length_grad = (gd[127:64] != 0) ? 32'hFFFF_FFFF : gd[63:32];
      res.saturated = clip || (gd[127:64] != 0);
      return res;
   endfunction

   initial begin
      for (int i = 0; i <= TAB_N; i++) pow2_frac_tab[i] = pow2_frac(i);
   end

   always @(posedge clock) begin
      logic [39:0] sq, nsum;
      logic        nclip;
      logic signed [16:0] diff;
      rsp_type     want;
      if (reset) begin
         dist_sum = '0;
         dist_clipped = 1'b0;
         reg_variance = 24'd65536;
         reg_inv_sq = 24'd65536;
         reg_inv_cubed = 24'd65536;
         kernel_results.delete();
         errors <= 0;
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VARIANCE: reg_variance = csr_wdata;
               CSR_INV_LENGTH_SQ: reg_inv_sq = csr_wdata;
               CSR_INV_LENGTH_CUBED: reg_inv_cubed = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            diff = 17'(req_data.coord_a) - 17'(req_data.coord_b);
            sq = 40'(diff < 0 ? -diff : diff);
            sq = sq * sq;
            nsum = dist_sum;
            nclip = dist_clipped;
            if (sq > DIST_MAX - nsum) begin
               nsum = DIST_MAX;
               nclip = 1'b1;
            end else begin
               nsum = nsum + sq;
            end
            if (req_data.last_coord) begin
               kernel_results.push_back(kernel_of(nsum, nclip));
               dist_sum = '0;
               dist_clipped = 1'b0;
            end else begin
               dist_sum = nsum;
               dist_clipped = nclip;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (kernel_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               errors <= errors + 1;
            end else begin
               want = kernel_results.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: mismatch kv exp %h act %h, exp_weight exp %h act %h",
                           $time, want.kernel_value, rsp_data.kernel_value,
                           want.exp_weight, rsp_data.exp_weight);
                  $display("%0t:   grad exp %h act %h, sat exp %b act %b",
                           $time, want.length_grad, rsp_data.length_grad,
                           want.saturated, rsp_data.saturated);
                  errors <= errors + 1;
               end
            end
         end
         outstanding <= kernel_results.size();
      end
   end

endmodule

`default_nettype wire

[verif/rbf_kernel_with_gradients_top_tb.sv]
`default_nettype none

module rbf_kernel_with_gradients_top_tb;
   import rbfk_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;

   int errors, outstanding;
   int send_idle = 0, recv_idle = 0;
   int cycles = 0;
   int items_sent = 0;
   int hold_requests = 0;
   logic req_fire = 1'b0, csr_fire = 1'b0;

   // clock: 20 units period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   rbf_kernel_with_gradients_top dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   rbf_kernel_with_gradients_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .errors, .outstanding
   );

   // register handshakes at the edge so the driver can read them at the falling edge
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      csr_fire <= csr_valid && csr_ready;
   end

   // cycle watchdog: end the run if the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("rbf_kernel_with_gradients_top_tb: FAIL");
         $finish;
      end
   end

   // receiver: random back-pressure, plus one long hold-off on demand
   always begin : receiver
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // offer one coordinate request; hold it until accepted
   task automatic send_coord(input logic [15:0] a, input logic [15:0] b, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{coord_a: a, coord_b: b, last_coord: last};
      do @(negedge clock); while (!req_fire);
      items_sent++;
   endtask

   // drain: drop valid, wait for every result, then cover back-end latency
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_kernel(input logic [23:0] v, input logic [23:0] s, input logic [23:0] c);
      write_csr(CSR_VARIANCE, v);
      write_csr(CSR_INV_LENGTH_SQ, s);
      write_csr(CSR_INV_LENGTH_CUBED, c);
   endtask

   function automatic logic [15:0] small_coord();
      return 16'($urandom_range(4095)) - 16'd2048;
   endfunction

   // random pairs: mostly short pairs near the origin, some full-range noise
   task automatic random_pairs(input int budget);
      int goal, len, pick;
      goal = items_sent + budget;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         len = (pick < 20) ? 1 : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            if (pick < 20)
               send_coord(16'($urandom), 16'($urandom), 1'b1);
            else if (pick < 25)
               send_coord(16'($urandom), 16'($urandom), i == len - 1);
            else
               send_coord(small_coord(), small_coord(), i == len - 1);
         end
      end
   endtask

   // long pair of extreme coordinates: drive the distance into saturation
   task automatic saturating_pair(input int len);
      for (int i = 0; i < len; i++)
         send_coord(16'h7FFF, 16'h8000, i == len - 1);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < 6; phase++) begin
         send_idle = (phase < 2) ? 37 : (phase < 4) ? 61 : 0;
         recv_idle = (phase < 2) ? 61 : (phase < 4) ? 37 : 0;
         case (phase)
            1: set_kernel(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
            2: set_kernel(24'd1, 24'd1, 24'd1);
            3: begin
               // zero registers, then an out-of-range index that must be ignored
               set_kernel(24'd0, 24'd0, 24'd0);
               write_csr(CSR_UNMAPPED, 24'h12_3456);
            end
            4: set_kernel(24'($urandom_range(1, 24'hFF_FFFF)),
                          24'($urandom_range(1, 24'h3_FFFF)),
                          24'($urandom_range(1, 24'hFF_FFFF)));
            5: set_kernel(24'd65536, 24'd4096, 24'hFF_FFFF);
            default: ;
         endcase
         if (phase == 0 || phase == 3) begin
            // directed: zero distance, extremes, multi-coordinate pairs
            send_coord(16'h0000, 16'h0000, 1'b1);
            send_coord(16'h7FFF, 16'h8000, 1'b1);
            send_coord(16'h8000, 16'h7FFF, 1'b1);
            send_coord(16'h1000, 16'h0000, 1'b1);
            send_coord(16'h0001, 16'h0000, 1'b0);
            send_coord(16'h0000, 16'h0001, 1'b1);
            send_coord(16'hFFFF, 16'h0000, 1'b1);
            send_coord(16'h5555, 16'hAAAA, 1'b0);
            send_coord(16'hAAAA, 16'h5555, 1'b1);
            send_coord(16'h0800, 16'hF800, 1'b1);
            send_coord(16'h0100, 16'h0080, 1'b0);
            send_coord(16'h0040, 16'h0000, 1'b0);
            send_coord(16'h0000, 16'h0020, 1'b1);
         end
         if (phase == 4) begin
            // stall the receiver while requests keep coming
            hold_requests++;
            random_pairs(60);
         end
         if (phase == 5) begin
            saturating_pair(270);
            random_pairs(40);
            // pause the sender until every result is back
            req_valid <= 1'b0;
            @(negedge clock);
            while (outstanding != 0) @(negedge clock);
         end
         random_pairs(40);
         drain();
      end

      if (errors == 0)
         $display("rbf_kernel_with_gradients_top_tb: PASS");
      else
         $display("rbf_kernel_with_gradients_top_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
src/rbfk_pkg.sv
src/rbfk_front.sv
src/rbfk_queue.sv
src/rbfk_mul.sv
src/rbfk_back.sv
src/rbf_kernel_with_gradients_top.sv
src/rbfk_checker.sv
verif/rbf_kernel_with_gradients_checker.sv
verif/rbf_kernel_with_gradients_top_tb.sv
